@@ hw/rtl/dssp_pkg.sv @@
// ----------------------------------------------------------------------------
// dssp_pkg
// Shared types and constants for the decimal size string parser: the
// input and result word layouts, status codes, and the character codes
// for digits, the terminator and the binary scale suffixes.
// ----------------------------------------------------------------------------
package dssp_pkg;

    // One input word: a start flag and one ASCII character
    typedef struct packed {
        logic       start_req;
        logic [7:0] ch;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_out_word;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Value limits for the digit overflow check
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_DIV10 = ALL_ONES / 64'd10;
    localparam logic [3:0]  LIMIT_REM10 = 4'(ALL_ONES % 64'd10);

    // Character codes
    localparam logic [7:0] CH_TERM  = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_KILO  = 8'h6B;  // k
    localparam logic [7:0] CH_MEGA  = 8'h4D;  // M
    localparam logic [7:0] CH_GIGA  = 8'h47;  // G
    localparam logic [7:0] CH_TERA  = 8'h54;  // T
    localparam logic [7:0] CH_PETA  = 8'h50;  // P
    localparam logic [7:0] CH_EXA   = 8'h45;  // E
    localparam logic [7:0] CH_ZETTA = 8'h5A;  // Z
    localparam logic [7:0] CH_YOTTA = 8'h59;  // Y

    // Scale shift width: up to 80 bits
    localparam int SH_W = 7;

endpackage

@@ hw/rtl/decimal_size_string_parser_core.sv @@
// An accepted word goes to the input register, and its result word is then
// loaded into the output register; words not ending a string give no result.
// Throughput: one word per cycle; the accumulator update (multiply by ten
// and add, plus the limit compare) is combinational. A word that ends
// a string waits in the input register while an earlier result is unread.
// Reset (synchronous, active low) clears the accumulator, the decided flag
// and both valid flags, and sets suffix_mode to 1.
// ----------------------------------------------------------------------------
// decimal_size_string_parser_core
// Parses a stream of ASCII characters into an unsigned 64-bit value with an
// optional binary scale suffix in suffix mode, giving one result word per string.
// ----------------------------------------------------------------------------
module decimal_size_string_parser_core
    import dssp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // Configuration
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    // Input channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    // Result channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic        r_suffix_mode;
    logic        r_in_valid;
    t_in_word    r_in;
    logic [63:0] r_acc;
    logic        r_decided;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        w_out_free;
    logic        w_advance;
    logic [63:0] w_acc_cur;
    logic        w_dec_cur;
    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic        w_digit_ok;
    logic [63:0] w_acc_mul;
    logic        w_sfx_hit;
    logic [SH_W-1:0] w_sh;
    logic [63:0] w_sh_limit;
    logic        w_has_result;
    t_out_word   w_result;
    logic [63:0] n_acc;
    logic        n_decided;

    // Handshake: input register drains when the result can go out or the word gives no result
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (w_out_free || !w_has_result);
    assign o_in_ready = !r_in_valid || w_advance;

    // Start clears the string state before the character is looked at
    assign w_acc_cur = r_in.start_req ? 64'd0 : r_acc;
    assign w_dec_cur = r_in.start_req ? 1'b0  : r_decided;

    // Digit path: acc * 10 + d with limit check
    assign w_is_digit = r_in.ch inside {[CH_ZERO:CH_NINE]};
    assign w_digit    = 4'(r_in.ch - CH_ZERO);
    assign w_digit_ok = (w_acc_cur < LIMIT_DIV10) ||
                        ((w_acc_cur == LIMIT_DIV10) && (w_digit <= LIMIT_REM10));
    assign w_acc_mul  = (w_acc_cur << 3) + (w_acc_cur << 1) + {60'd0, w_digit};

    // Terminator / suffix decode
    always_comb begin
        w_sfx_hit = 1'b1;
        case (r_in.ch)
            CH_TERM:  w_sh = SH_W'(0);
            CH_KILO:  w_sh = SH_W'(10);
            CH_MEGA:  w_sh = SH_W'(20);
            CH_GIGA:  w_sh = SH_W'(30);
            CH_TERA:  w_sh = SH_W'(40);
            CH_PETA:  w_sh = SH_W'(50);
            CH_EXA:   w_sh = SH_W'(60);
            CH_ZETTA: w_sh = SH_W'(70);
            CH_YOTTA: w_sh = SH_W'(80);
            default: begin
                w_sh      = SH_W'(0);
                w_sfx_hit = 1'b0;
            end
        endcase
    end

    // Largest value that survives the shift (zero for shifts of 64 and up)
    assign w_sh_limit = ALL_ONES >> w_sh;

    // Result decision
    always_comb begin
        w_result.value  = 64'd0;
        w_result.status = ST_OK;
        if (w_is_digit) begin
            w_result.status = ST_OVERFLOW;
        end else if (r_suffix_mode) begin
            if (!w_sfx_hit) begin
                w_result.status = ST_INVALID;
            end else if (w_acc_cur == 64'd0) begin
                w_result.status = ST_OK;
            end else if (w_acc_cur > w_sh_limit) begin
                w_result.status = ST_OVERFLOW;
            end else begin
                w_result.value = w_acc_cur << w_sh[5:0];
            end
        end else if (r_in.ch == CH_TERM) begin
            w_result.value = w_acc_cur;
        end else begin
            w_result.status = ST_INVALID;
        end
    end

    assign w_has_result = !w_dec_cur && !(w_is_digit && w_digit_ok);

    // Next string state
    always_comb begin
        n_acc     = w_acc_cur;
        n_decided = w_dec_cur || w_has_result;
        if (!w_dec_cur && w_is_digit && w_digit_ok) begin
            n_acc = w_acc_mul;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suffix_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_suffix_mode <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // String state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 64'd0;
            r_decided <= 1'b0;
        end else if (w_advance) begin
            r_acc     <= n_acc;
            r_decided <= n_decided;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Checks

    // A failed string carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK) |-> o_out_word.value == 64'd0)
        else $error("non-zero value on failed result");

    // Status is never the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_OK) || (o_out_word.status == ST_INVALID)
                        || (o_out_word.status == ST_OVERFLOW))
        else $error("unused status code");

    // Once decided, no further result until a new string starts
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_decided && !r_in.start_req |-> !w_has_result)
        else $error("second result within one string");

    // A word held back in the input register is not lost
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("stalled input word lost");

    // An unread result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule
